[design/acm_pkg.sv]
// shared constants for the averaged calibrated meter
`timescale 1ns / 1ps
`default_nettype none

package acm_pkg;

    // field widths
    localparam int SAMPLE_BITS = 12;
    localparam int COUNT_W     = 8;
    localparam int OFFSET_W    = 22;
    localparam int GAIN_W      = 32;
    localparam int READING_W   = 32;
    localparam int SUM_W       = 20;
    localparam int SETTLE_W    = 4;

    // datapath widths
    localparam int MEAN_W = SUM_W + 8;        // mean in Q.8
    localparam int DIFF_W = MEAN_W + 2;       // signed mean minus offset
    localparam int MAG_W  = DIFF_W - 1;       // magnitude of the difference
    localparam int PROD_W = MAG_W + GAIN_W;   // magnitude product in Q.24
    localparam int RND_W  = PROD_W - 16;      // product back in Q.8

    // configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [SETTLE_W-1:0] SETTLE_POLLS = 4'd10;
    localparam logic [SUM_W-1:0]    SUM_MAX      = {SUM_W{1'b1}};

    // register indexes
    localparam logic [2:0] REG_MEAS_MODE      = 3'd0;
    localparam logic [2:0] REG_WINDOW_COUNT   = 3'd1;
    localparam logic [2:0] REG_CURRENT_OFFSET = 3'd2;
    localparam logic [2:0] REG_CURRENT_GAIN   = 3'd3;
    localparam logic [2:0] REG_CURRENT_CLAMP  = 3'd4;
    localparam logic [2:0] REG_VOLTAGE_OFFSET = 3'd5;
    localparam logic [2:0] REG_VOLTAGE_GAIN   = 3'd6;
    localparam logic [2:0] REG_VOLTAGE_CLAMP  = 3'd7;

endpackage

`default_nettype wire

[design/averaged_calibrated_meter.sv]
// averaged calibrated meter: poll window averaging with offset and slope calibration
//
// Usage: each transfer on the s_ channel is one converter poll (s_adc_sample,
// s_sample_ok). After reset or any register write the first ten polls are
// skipped. Valid samples are then summed over window_count samples (every
// sample when window_count is 0); the window mean is offset-corrected, scaled
// by the slope of the selected mode, rounded, saturated and optionally clamped
// at zero, and sent as one m_reading transfer.
// A poll that closes no window leaves the block ready for the next poll. A
// poll that closes a window holds s_ready low until its result has passed
// the bit-serial restoring divider (skipped when window_count is 0), the
// difference, the multiplier load, the bit-serial shift-add multiplier and
// the rounding and saturation step.
// The result sits in an output register, so polls keep flowing while it
// waits; if a second result is ready before the first is taken, the final
// step holds until m_ready frees the register.
// Reset (synchronous, active low) loads the register defaults, clears the
// window and arms the settle counter; registers are written at 4*index.
`timescale 1ns / 1ps
`default_nettype none

module averaged_calibrated_meter (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // poll channel
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [acm_pkg::SAMPLE_BITS-1:0]     s_adc_sample,
    input  wire logic                                s_sample_ok,
    // result channel
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [acm_pkg::READING_W-1:0]     m_reading,
    // configuration port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [acm_pkg::ADDR_W-1:0]          paddr,
    input  wire logic [acm_pkg::DATA_W-1:0]          pwdata,
    output logic [acm_pkg::DATA_W-1:0]               prdata,
    output logic                                     pready
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_DIFF = 3'd2;
    localparam logic [2:0] ST_LOAD = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    localparam logic [4:0] DIV_LAST = 5'(acm_pkg::MEAN_W - 1);
    localparam logic [4:0] MUL_LAST = 5'(acm_pkg::MAG_W - 1);

    localparam logic [acm_pkg::RND_W-1:0] POS_LIMIT = acm_pkg::RND_W'(32'h7FFF_FFFF);
    localparam logic [acm_pkg::RND_W-1:0] NEG_LIMIT = acm_pkg::RND_W'(32'h8000_0000);

    // configuration registers
    logic                                   meas_mode_reg;
    logic [acm_pkg::COUNT_W-1:0]            window_count_reg;
    logic signed [acm_pkg::OFFSET_W-1:0]    current_offset_reg;
    logic signed [acm_pkg::GAIN_W-1:0]      current_gain_reg;
    logic                                   current_clamp_reg;
    logic signed [acm_pkg::OFFSET_W-1:0]    voltage_offset_reg;
    logic signed [acm_pkg::GAIN_W-1:0]      voltage_gain_reg;
    logic                                   voltage_clamp_reg;

    // window state
    logic [acm_pkg::SUM_W-1:0]              window_sum_reg;
    logic [acm_pkg::COUNT_W-1:0]            window_left_reg;
    logic [acm_pkg::SETTLE_W-1:0]           settle_left_reg;

    // sequencer and datapath
    logic [2:0]                             state_reg;
    logic [4:0]                             step_reg;
    logic [acm_pkg::MEAN_W-1:0]             quot_reg;
    logic [acm_pkg::COUNT_W-1:0]            rem_reg;
    logic signed [acm_pkg::DIFF_W-1:0]      diff_reg;
    logic [acm_pkg::GAIN_W-1:0]             prod_hi_reg;
    logic [acm_pkg::MAG_W-1:0]              prod_lo_reg;
    logic [acm_pkg::GAIN_W-1:0]             gain_mag_reg;
    logic                                   neg_reg;
    logic                                   clamp_reg;

    // output register
    logic                                   m_valid_reg;
    logic signed [acm_pkg::READING_W-1:0]   m_reading_reg;

    logic                                   cfg_write;
    logic [2:0]                             cfg_index;
    logic                                   poll_take;
    logic [acm_pkg::SUM_W:0]                sum_add;
    logic [acm_pkg::SUM_W-1:0]              sum_sat;
    logic [acm_pkg::COUNT_W-1:0]            left_dec;
    logic [acm_pkg::COUNT_W:0]              rem_shift;
    logic [acm_pkg::COUNT_W:0]              rem_sub;
    logic                                   rem_ge;
    logic signed [acm_pkg::OFFSET_W-1:0]    sel_offset;
    logic signed [acm_pkg::GAIN_W-1:0]      sel_gain;
    logic                                   sel_clamp;
    logic [acm_pkg::MAG_W-1:0]              diff_mag;
    logic [acm_pkg::GAIN_W-1:0]             gain_mag;
    logic [acm_pkg::GAIN_W:0]               mul_add;
    logic [acm_pkg::PROD_W-1:0]             prod_full;
    logic [acm_pkg::RND_W-1:0]              rnd_mag;
    logic signed [acm_pkg::READING_W-1:0]   result;
    logic                                   out_free;
    logic                                   out_load;

    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[4:2];
    assign pready    = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign poll_take = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_reading = m_reading_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign out_load  = (state_reg == ST_DONE) && out_free && !cfg_write;

    // register readback
    always_comb begin
        unique case (cfg_index)
            acm_pkg::REG_MEAS_MODE:      prdata = 32'(meas_mode_reg);
            acm_pkg::REG_WINDOW_COUNT:   prdata = 32'(window_count_reg);
            acm_pkg::REG_CURRENT_OFFSET: prdata = 32'(current_offset_reg);
            acm_pkg::REG_CURRENT_GAIN:   prdata = current_gain_reg;
            acm_pkg::REG_CURRENT_CLAMP:  prdata = 32'(current_clamp_reg);
            acm_pkg::REG_VOLTAGE_OFFSET: prdata = 32'(voltage_offset_reg);
            acm_pkg::REG_VOLTAGE_GAIN:   prdata = voltage_gain_reg;
            acm_pkg::REG_VOLTAGE_CLAMP:  prdata = 32'(voltage_clamp_reg);
        endcase
    end

    // window accumulation with saturation
    always_comb begin
        sum_add  = {1'b0, window_sum_reg} + (acm_pkg::SUM_W + 1)'(s_adc_sample);
        sum_sat  = sum_add[acm_pkg::SUM_W] ? acm_pkg::SUM_MAX : sum_add[acm_pkg::SUM_W-1:0];
        left_dec = (window_left_reg != '0) ? window_left_reg - 1'b1 : window_left_reg;
    end

    // one restoring divide step
    always_comb begin
        rem_shift = {rem_reg, quot_reg[acm_pkg::MEAN_W-1]};
        rem_sub   = rem_shift - {1'b0, window_count_reg};
        rem_ge    = (rem_shift >= {1'b0, window_count_reg});
    end

    // mode selection and magnitudes
    always_comb begin
        sel_offset = meas_mode_reg ? voltage_offset_reg : current_offset_reg;
        sel_gain   = meas_mode_reg ? voltage_gain_reg   : current_gain_reg;
        sel_clamp  = meas_mode_reg ? voltage_clamp_reg  : current_clamp_reg;
        diff_mag   = diff_reg[acm_pkg::DIFF_W-1] ? acm_pkg::MAG_W'(-diff_reg)
                                                 : acm_pkg::MAG_W'(diff_reg);
        gain_mag   = sel_gain[acm_pkg::GAIN_W-1] ? 32'(-sel_gain) : 32'(sel_gain);
    end

    // one shift-add multiply step
    assign mul_add = {1'b0, prod_hi_reg}
                   + (prod_lo_reg[0] ? {1'b0, gain_mag_reg} : '0);

    // round to nearest, saturate, clamp
    always_comb begin
        prod_full = {prod_hi_reg, prod_lo_reg};
        rnd_mag   = prod_full[acm_pkg::PROD_W-1:16] + acm_pkg::RND_W'(prod_full[15]);
        if (neg_reg) begin
            result = (rnd_mag > NEG_LIMIT) ? 32'sh8000_0000 : -$signed(rnd_mag[31:0]);
        end else begin
            result = (rnd_mag > POS_LIMIT) ? 32'sh7FFF_FFFF : $signed(rnd_mag[31:0]);
        end
        if (clamp_reg && result[31]) begin
            result = '0;
        end
    end

    // output register: loaded from the final step, cleared by the transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_reading_reg <= result;
            m_valid_reg   <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // configuration, window state and sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            meas_mode_reg      <= 1'b1;
            window_count_reg   <= '0;
            current_offset_reg <= '0;
            current_gain_reg   <= '0;
            current_clamp_reg  <= 1'b0;
            voltage_offset_reg <= '0;
            voltage_gain_reg   <= '0;
            voltage_clamp_reg  <= 1'b0;
            window_sum_reg     <= '0;
            window_left_reg    <= '0;
            settle_left_reg    <= acm_pkg::SETTLE_POLLS;
            state_reg          <= ST_IDLE;
            step_reg           <= '0;
        end else begin
            if (cfg_write) begin
                window_sum_reg  <= '0;
                window_left_reg <= window_count_reg;
                settle_left_reg <= acm_pkg::SETTLE_POLLS;
                unique case (cfg_index)
                    acm_pkg::REG_MEAS_MODE:      meas_mode_reg <= pwdata[0];
                    acm_pkg::REG_WINDOW_COUNT: begin
                        window_count_reg <= pwdata[acm_pkg::COUNT_W-1:0];
                        window_left_reg  <= pwdata[acm_pkg::COUNT_W-1:0];
                    end
                    acm_pkg::REG_CURRENT_OFFSET: current_offset_reg <= pwdata[acm_pkg::OFFSET_W-1:0];
                    acm_pkg::REG_CURRENT_GAIN:   current_gain_reg   <= pwdata;
                    acm_pkg::REG_CURRENT_CLAMP:  current_clamp_reg  <= pwdata[0];
                    acm_pkg::REG_VOLTAGE_OFFSET: voltage_offset_reg <= pwdata[acm_pkg::OFFSET_W-1:0];
                    acm_pkg::REG_VOLTAGE_GAIN:   voltage_gain_reg   <= pwdata;
                    acm_pkg::REG_VOLTAGE_CLAMP:  voltage_clamp_reg  <= pwdata[0];
                endcase
            end else begin
                unique case (state_reg)
                    ST_IDLE: begin
                        // poll transfer: settle, skip timeouts, accumulate
                        if (poll_take) begin
                            if (settle_left_reg != '0) begin
                                settle_left_reg <= settle_left_reg - 1'b1;
                            end else if (s_sample_ok) begin
                                if (left_dec == '0) begin
                                    quot_reg        <= {sum_sat, 8'd0};
                                    rem_reg         <= '0;
                                    step_reg        <= '0;
                                    window_sum_reg  <= '0;
                                    window_left_reg <= window_count_reg;
                                    state_reg       <= (window_count_reg == '0) ? ST_DIFF : ST_DIV;
                                end else begin
                                    window_sum_reg  <= sum_sat;
                                    window_left_reg <= left_dec;
                                end
                            end
                        end
                    end
                    ST_DIV: begin
                        // one quotient bit per cycle while no register write holds the sequencer
                        quot_reg <= {quot_reg[acm_pkg::MEAN_W-2:0], rem_ge};
                        rem_reg  <= rem_ge ? rem_sub[acm_pkg::COUNT_W-1:0]
                                           : rem_shift[acm_pkg::COUNT_W-1:0];
                        step_reg <= step_reg + 1'b1;
                        if (step_reg == DIV_LAST) begin
                            state_reg <= ST_DIFF;
                        end
                    end
                    ST_DIFF: begin
                        diff_reg  <= $signed({2'b00, quot_reg})
                                   - acm_pkg::DIFF_W'(sel_offset);
                        state_reg <= ST_LOAD;
                    end
                    ST_LOAD: begin
                        prod_hi_reg  <= '0;
                        prod_lo_reg  <= diff_mag;
                        gain_mag_reg <= gain_mag;
                        neg_reg      <= diff_reg[acm_pkg::DIFF_W-1] ^ sel_gain[acm_pkg::GAIN_W-1];
                        clamp_reg    <= sel_clamp;
                        step_reg     <= '0;
                        state_reg    <= ST_MUL;
                    end
                    ST_MUL: begin
                        // one multiplier bit per cycle while no register write holds the sequencer
                        prod_hi_reg <= mul_add[acm_pkg::GAIN_W:1];
                        prod_lo_reg <= {mul_add[0], prod_lo_reg[acm_pkg::MAG_W-1:1]};
                        step_reg    <= step_reg + 1'b1;
                        if (step_reg == MUL_LAST) begin
                            state_reg <= ST_DONE;
                        end
                    end
                    ST_DONE: begin
                        // hand the result to the output register once it is free
                        if (out_free) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                    default: begin
                        state_reg <= ST_IDLE;
                    end
                endcase
            end
        end
    end

`ifndef SYNTH
    // settle counter never rises above its reload value
    assert property (@(posedge aclk) disable iff (!aresetn)
        settle_left_reg <= acm_pkg::SETTLE_POLLS)
        else $error("settle counter out of range");

    // samples still missing never exceed the window length
    assert property (@(posedge aclk) disable iff (!aresetn)
        window_left_reg <= window_count_reg)
        else $error("window counter above window length");

    // divider remainder stays below the divisor
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < window_count_reg))
        else $error("divider remainder not reduced");

    // a clamped mode never delivers a negative reading
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_free && clamp_reg && !cfg_write)
        |=> (m_valid_reg && !m_reading_reg[31]))
        else $error("clamped reading is negative");
`endif

endmodule

`default_nettype wire

[bench/averaged_calibrated_meter_tb.sv]
// self-checking testbench for the averaged calibrated meter
`timescale 1ns / 1ps

module averaged_calibrated_meter_tb;

    localparam int ITEM_TARGET    = 2000;
    localparam int CALM_AFTER     = 1700;
    localparam int HOLD_LEN       = 400;
    localparam int IDLE_TAIL      = 80;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam logic [acm_pkg::SETTLE_W-1:0] SETTLE_COUNT = 4'd10;

    // running model of the meter: registers, window state and pending readings
    class meter_scoreboard;
        logic                                 mode;
        logic [acm_pkg::COUNT_W-1:0]          win_count;
        logic signed [acm_pkg::OFFSET_W-1:0]  cur_offset, volt_offset;
        logic signed [acm_pkg::GAIN_W-1:0]    cur_gain, volt_gain;
        logic                                 cur_clamp, volt_clamp;
        logic [acm_pkg::SUM_W-1:0]            sum_acc;
        logic [acm_pkg::COUNT_W-1:0]          win_left;
        logic [acm_pkg::SETTLE_W-1:0]         settle_left;
        logic [acm_pkg::READING_W-1:0]        expected_readings[$];
        int                                   mismatches;

        function new();
            mode        = 1'b1;
            win_count   = '0;
            cur_offset  = '0;
            cur_gain    = '0;
            cur_clamp   = 1'b0;
            volt_offset = '0;
            volt_gain   = '0;
            volt_clamp  = 1'b0;
            mismatches  = 0;
            restart();
        endfunction

        function void restart();
            sum_acc     = '0;
            win_left    = win_count;
            settle_left = SETTLE_COUNT;
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction

        // any register write restarts the window and the settle count
        function void write_reg(logic [2:0] idx, logic [acm_pkg::DATA_W-1:0] val);
            case (idx)
                acm_pkg::REG_MEAS_MODE:      mode        = val[0];
                acm_pkg::REG_WINDOW_COUNT:   win_count   = val[acm_pkg::COUNT_W-1:0];
                acm_pkg::REG_CURRENT_OFFSET: cur_offset  = val[acm_pkg::OFFSET_W-1:0];
                acm_pkg::REG_CURRENT_GAIN:   cur_gain    = val[acm_pkg::GAIN_W-1:0];
                acm_pkg::REG_CURRENT_CLAMP:  cur_clamp   = val[0];
                acm_pkg::REG_VOLTAGE_OFFSET: volt_offset = val[acm_pkg::OFFSET_W-1:0];
                acm_pkg::REG_VOLTAGE_GAIN:   volt_gain   = val[acm_pkg::GAIN_W-1:0];
                acm_pkg::REG_VOLTAGE_CLAMP:  volt_clamp  = val[0];
                default:                     return;
            endcase
            restart();
        endfunction

        // accepted poll: accumulate and, at the end of a window, predict the reading
        function void note_poll(logic [acm_pkg::SAMPLE_BITS-1:0] smp, logic ok);
            logic [acm_pkg::SUM_W:0] grown;
            logic [63:0]             mean_q8, mag_d, mag_g, prod;
            longint                  off, gain, diff, res;
            logic                    clamp, negative;
            if (settle_left != 0) begin
                settle_left = settle_left - 1'b1;
                return;
            end
            if (!ok)
                return;
            grown   = {1'b0, sum_acc} + (acm_pkg::SUM_W + 1)'(smp);
            sum_acc = grown[acm_pkg::SUM_W] ? {acm_pkg::SUM_W{1'b1}}
                                            : grown[acm_pkg::SUM_W-1:0];
            if (win_left != 0)
                win_left = win_left - 1'b1;
            if (win_left != 0)
                return;

            // window closed: mean in Q.8
            win_left = win_count;
            mean_q8  = 64'(sum_acc) << 8;
            if (win_count != 0)
                mean_q8 = mean_q8 / 64'(win_count);
            sum_acc = '0;

            if (mode) begin
                off   = volt_offset;
                gain  = volt_gain;
                clamp = volt_clamp;
            end else begin
                off   = cur_offset;
                gain  = cur_gain;
                clamp = cur_clamp;
            end

            // sign-magnitude multiply, round half away from zero, saturate
            diff     = longint'(mean_q8) - off;
            negative = (diff < 0) != (gain < 0);
            mag_d    = (diff < 0) ? -diff : diff;
            mag_g    = (gain < 0) ? -gain : gain;
            prod     = (mag_d * mag_g + 64'h8000) >> 16;
            if (negative)
                res = (prod > 64'h8000_0000) ? -64'sh8000_0000 : -longint'(prod);
            else
                res = (prod > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(prod);
            if (clamp && res < 0)
                res = 0;
            expected_readings.push_back(res[acm_pkg::READING_W-1:0]);
        endfunction

        // accepted result against the oldest prediction
        function void check_reading(logic [acm_pkg::READING_W-1:0] got);
            logic [acm_pkg::READING_W-1:0] want;
            if (expected_readings.size() == 0) begin
                $error("reading: expected none, got %0d", $signed(got));
                mismatches++;
                return;
            end
            want = expected_readings.pop_front();
            if (got !== want) begin
                $error("reading: expected %0d, got %0d", $signed(want), $signed(got));
                mismatches++;
            end
        endfunction
    endclass

    logic                                 aclk;
    logic                                 aresetn;
    logic                                 s_valid;
    logic                                 s_ready;
    logic [acm_pkg::SAMPLE_BITS-1:0]      s_adc_sample;
    logic                                 s_sample_ok;
    logic                                 m_valid;
    logic                                 m_ready;
    logic signed [acm_pkg::READING_W-1:0] m_reading;
    logic                                 psel;
    logic                                 penable;
    logic                                 pwrite;
    logic [acm_pkg::ADDR_W-1:0]           paddr;
    logic [acm_pkg::DATA_W-1:0]           pwdata;
    logic [acm_pkg::DATA_W-1:0]           prdata;
    logic                                 pready;

    meter_scoreboard sb = new();

    int items_sent   = 0;
    int gap_odds     = 4;
    int sink_odds    = 4;
    bit calm         = 1'b0;
    bit sink_hold_req = 1'b0;
    int stall_cycles = 0;

    averaged_calibrated_meter dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_adc_sample (s_adc_sample),
        .s_sample_ok  (s_sample_ok),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_reading    (m_reading),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // transfer monitor and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_poll(s_adc_sample, s_sample_ok);
            if (m_valid && m_ready)
                sb.check_reading(m_reading);
            if (psel && penable && pwrite && pready)
                sb.write_reg(paddr[acm_pkg::ADDR_W-1:2], pwdata);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("averaged_calibrated_meter_tb NOT OK");
                $finish;
            end
        end
    end

    // result sink: random stall bursts, plus one long hold-off on request
    initial begin : result_sink
        int burst;
        int hold_left;
        burst     = 0;
        hold_left = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_hold_req) begin
                hold_left     = HOLD_LEN;
                sink_hold_req = 1'b0;
            end
            if (hold_left == 0 && burst == 0 && !calm && sink_odds != 0 &&
                $urandom_range(1, sink_odds) == 1)
                burst = $urandom_range(1, 16);
            if (hold_left != 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (burst != 0) begin
                m_ready <= 1'b0;
                burst--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic logic [acm_pkg::SAMPLE_BITS-1:0] random_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return acm_pkg::SAMPLE_BITS'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic logic [acm_pkg::DATA_W-1:0] random_offset();
        int v;
        case ($urandom_range(0, 5))
            0: return 32'hFFE0_0000;
            1: return 32'h001F_FFFF;
            2: return '0;
            3: begin
                v = $urandom_range(0, 600000) - 300000;
                return v;
            end
            default: begin
                v = $urandom;
                return {{(acm_pkg::DATA_W-acm_pkg::OFFSET_W){v[acm_pkg::OFFSET_W-1]}},
                        v[acm_pkg::OFFSET_W-1:0]};
            end
        endcase
    endfunction

    function automatic logic [acm_pkg::DATA_W-1:0] random_gain();
        int v;
        case ($urandom_range(0, 6))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3, 4: begin
                // slopes within plus or minus two
                v = $urandom_range(0, 32'h4_0000) - 32'h2_0000;
                return v;
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [acm_pkg::DATA_W-1:0] random_window();
        case ($urandom_range(0, 19))
            0, 1, 2: return 0;
            3:       return 255;
            4, 5:    return $urandom_range(0, 40);
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    // one register write: setup phase, access phase, then an idle phase
    task automatic apb_write(input logic [2:0] idx, input logic [acm_pkg::DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    // one poll transfer, with an optional gap before it
    task automatic send_poll(input logic [acm_pkg::SAMPLE_BITS-1:0] smp, input logic ok);
        int gap;
        if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            gap = $urandom_range(1, 16);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_adc_sample <= smp;
        s_sample_ok  <= ok;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        items_sent++;
        if (items_sent >= CALM_AFTER)
            calm = 1'b1;
    endtask

    // stop offering polls until every predicted reading has arrived
    task automatic wait_for_readings();
        s_valid <= 1'b0;
        do @(negedge aclk); while (sb.pending() != 0);
    endtask

    // idle the block fully so registers may be written
    task automatic wait_idle();
        wait_for_readings();
        repeat (IDLE_TAIL) @(negedge aclk);
    endtask

    // write a random subset of registers, or all of them
    task automatic random_config(input bit write_all, input int forced_window);
        logic [acm_pkg::DATA_W-1:0] vals [8];
        bit                         hit  [8];
        bit                         any;
        vals[acm_pkg::REG_MEAS_MODE]      = $urandom_range(0, 1);
        vals[acm_pkg::REG_WINDOW_COUNT]   = random_window();
        vals[acm_pkg::REG_CURRENT_OFFSET] = random_offset();
        vals[acm_pkg::REG_CURRENT_GAIN]   = random_gain();
        vals[acm_pkg::REG_CURRENT_CLAMP]  = $urandom_range(0, 1);
        vals[acm_pkg::REG_VOLTAGE_OFFSET] = random_offset();
        vals[acm_pkg::REG_VOLTAGE_GAIN]   = random_gain();
        vals[acm_pkg::REG_VOLTAGE_CLAMP]  = $urandom_range(0, 1);
        any = 1'b0;
        for (int i = 0; i < 8; i++) begin
            hit[i] = write_all || ($urandom_range(0, 1) == 1);
            any    = any | hit[i];
        end
        if (forced_window >= 0) begin
            vals[acm_pkg::REG_WINDOW_COUNT] = forced_window;
            hit[acm_pkg::REG_WINDOW_COUNT]  = 1'b1;
        end
        if (!any)
            hit[acm_pkg::REG_WINDOW_COUNT] = 1'b1;
        for (int i = 0; i < 8; i++)
            if (hit[i])
                apb_write(3'(i), vals[i]);
    endtask

    // stimulus
    initial begin : stimulus
        int phase;
        int n;
        int ok_odds;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_adc_sample = '0;
        s_sample_ok  = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset defaults: settle polls, then extremes and a timeout
        for (int i = 0; i < 10; i++)
            send_poll(random_sample(), i[0]);
        send_poll('0, 1'b1);
        send_poll('1, 1'b1);
        send_poll('1, 1'b0);

        // extreme calibration: full-scale sample saturates high
        wait_idle();
        apb_write(acm_pkg::REG_MEAS_MODE, 32'd1);
        apb_write(acm_pkg::REG_WINDOW_COUNT, 32'd0);
        apb_write(acm_pkg::REG_CURRENT_OFFSET, 32'h001F_FFFF);
        apb_write(acm_pkg::REG_CURRENT_GAIN, 32'h8000_0000);
        apb_write(acm_pkg::REG_CURRENT_CLAMP, 32'd1);
        apb_write(acm_pkg::REG_VOLTAGE_OFFSET, 32'hFFE0_0000);
        apb_write(acm_pkg::REG_VOLTAGE_GAIN, 32'h7FFF_FFFF);
        apb_write(acm_pkg::REG_VOLTAGE_CLAMP, 32'd0);
        for (int i = 0; i < 10; i++)
            send_poll(random_sample(), 1'b1);
        send_poll('1, 1'b1);

        // random phases, each with its own register setting
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            wait_idle();
            case ($urandom_range(0, 2))
                0:       gap_odds = 0;
                1:       gap_odds = 3;
                default: gap_odds = 12;
            endcase
            case ($urandom_range(0, 2))
                0:       sink_odds = 0;
                1:       sink_odds = 3;
                default: sink_odds = 12;
            endcase
            ok_odds = ($urandom_range(0, 9) == 0) ? 2 : 8;
            case (phase)
                0:       random_config(1'b1, -1);
                1:       random_config(1'b0, 255);
                2:       random_config(1'b0, 0);
                default: random_config(1'b0, -1);
            endcase
            n = $urandom_range(30, 80) + 2 * int'(sb.win_count);

            // settle polls, valid or not
            for (int i = 0; i < 10; i++)
                send_poll(random_sample(), 1'($urandom_range(0, 1)));

            // long receiver hold-off with back-to-back polls fills the block
            if (phase == 2) begin
                gap_odds      = 0;
                sink_hold_req = 1'b1;
                repeat (30) send_poll(random_sample(), 1'b1);
            end

            for (int i = 0; i < n && items_sent < ITEM_TARGET; i++) begin
                if (phase == 4 && i == n / 2)
                    wait_for_readings();
                send_poll(random_sample(), $urandom_range(1, ok_odds) != 1);
            end
            phase++;
        end

        // drain and give verdict
        wait_idle();
        if (sb.pending() != 0)
            $error("reading: %0d expected transfers never arrived", sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("averaged_calibrated_meter_tb OK");
        else
            $display("averaged_calibrated_meter_tb NOT OK");
        $finish;
    end

endmodule
